// ===== design/thc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the temperature/humidity compensation block.
// No dependencies; every other file in design/ uses this package.
package thc_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_TEMP_CAL_1  = 3'd0;
    localparam logic [2:0] REG_TEMP_CAL_2  = 3'd1;
    localparam logic [2:0] REG_TEMP_CAL_3  = 3'd2;
    localparam logic [2:0] REG_HUM_CAL_1   = 3'd3;
    localparam logic [2:0] REG_HUM_CAL_2   = 3'd4;
    localparam logic [2:0] REG_HUM_CAL_3   = 3'd5;
    localparam logic [2:0] REG_HUM_CAL_4_5 = 3'd6;
    localparam logic [2:0] REG_HUM_CAL_6   = 3'd7;

    localparam int CFG_DATA_W = 24;

    // Compensation constants
    localparam logic signed [31:0] HUM_T_OFFSET   = 32'sd76800;
    localparam logic signed [31:0] HUM_ROUND      = 32'sd16384;
    localparam logic signed [31:0] HUM_H3_BIAS    = 32'sd32768;
    localparam logic signed [31:0] HUM_H2_BIAS    = 32'sd2097152;
    localparam logic signed [31:0] HUM_GAIN_ROUND = 32'sd8192;
    localparam logic signed [31:0] HUM_MAX        = 32'sd419430400;
    localparam logic signed [31:0] TEMP_ROUND     = 32'sd128;
    localparam logic [16:0]        HUM_Q10_MAX    = 17'd102400;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic        [16:0] humidity_q10;
    } out_item_t;

    // Calibration words as held in the configuration registers
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [23:0] h45;
        logic [7:0]  h6;
    } cal_t;

    // Handoff from the temperature pipe to the humidity pipe
    typedef struct packed {
        logic [15:0]        raw_humidity;
        logic signed [31:0] fine;
        logic signed [23:0] temp_centi;
        logic signed [31:0] x;
    } temp_stage_t;

endpackage

// ===== design/thc_temp_pipe.sv =====
`timescale 1ns / 1ps
// Five-stage temperature pipeline: raw temperature to fine and centi-degree values.
// Depends on thc_pkg.
module thc_temp_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  thc_pkg::in_item_t    in_data,
    input  thc_pkg::cal_t        cal,
    output logic                 out_valid,
    output thc_pkg::temp_stage_t out_stage
);

    logic [4:0] valid_reg;

    logic signed [31:0] t1_x, t2_x, t3_x;

    logic signed [31:0] ta_next, d_next;
    logic signed [31:0] s1_ta_reg, s1_d_reg;
    logic [15:0]        s1_h_reg;

    logic signed [31:0] s2_pa_reg, s2_dd_reg;
    logic [15:0]        s2_h_reg;

    logic signed [31:0] s3_a_reg, s3_pb_reg, dd_shr;
    logic [15:0]        s3_h_reg;

    logic signed [31:0] s4_fine_reg;
    logic [15:0]        s4_h_reg;

    logic signed [31:0] temp_next;
    logic signed [31:0] s5_fine_reg, s5_x_reg;
    logic signed [23:0] s5_temp_reg;
    logic [15:0]        s5_h_reg;

    assign t1_x = {16'b0, cal.t1};
    assign t2_x = {{16{cal.t2[15]}}, cal.t2};
    assign t3_x = {{16{cal.t3[15]}}, cal.t3};

    assign ta_next = {15'b0, in_data.raw_temperature[19:3]} - {15'b0, cal.t1, 1'b0};
    assign d_next  = {16'b0, in_data.raw_temperature[19:4]} - t1_x;
    assign dd_shr  = s2_dd_reg >>> 12;
    assign temp_next = ((s4_fine_reg <<< 2) + s4_fine_reg + thc_pkg::TEMP_ROUND) >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ta_reg   <= ta_next;
            s1_d_reg    <= d_next;
            s1_h_reg    <= in_data.raw_humidity;

            s2_pa_reg   <= s1_ta_reg * t2_x;
            s2_dd_reg   <= s1_d_reg * s1_d_reg;
            s2_h_reg    <= s1_h_reg;

            s3_a_reg    <= s2_pa_reg >>> 11;
            s3_pb_reg   <= dd_shr * t3_x;
            s3_h_reg    <= s2_h_reg;

            s4_fine_reg <= s3_a_reg + (s3_pb_reg >>> 14);
            s4_h_reg    <= s3_h_reg;

            s5_temp_reg <= temp_next[23:0];
            s5_fine_reg <= s4_fine_reg;
            s5_x_reg    <= s4_fine_reg - thc_pkg::HUM_T_OFFSET;
            s5_h_reg    <= s4_h_reg;
        end
    end

    assign out_valid              = valid_reg[4];
    assign out_stage.raw_humidity = s5_h_reg;
    assign out_stage.fine         = s5_fine_reg;
    assign out_stage.temp_centi   = s5_temp_reg;
    assign out_stage.x            = s5_x_reg;

endmodule

// ===== design/thc_hum_pipe.sv =====
`timescale 1ns / 1ps
// Seven-stage humidity pipeline, last stage is the output register.
// Depends on thc_pkg.
module thc_hum_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  thc_pkg::temp_stage_t in_stage,
    input  thc_pkg::cal_t        cal,
    output logic                 out_valid,
    output thc_pkg::out_item_t   out_data
);

    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [23:0] temp;
    } carry_t;

    logic [6:0] valid_reg;

    logic signed [31:0] h1_x, h2_x, h3_x, h4_x, h5_x, h6_x;

    carry_t             c6_reg, c7_reg, c8_reg, c9_reg, c10_reg, c11_reg;

    logic signed [31:0] s6_m5_reg, s6_q0_reg, s6_r0_reg;
    logic [15:0]        s6_h_reg;

    logic signed [31:0] p_next, q_val, r_val;
    logic signed [31:0] s7_p_reg, s7_qr_reg;

    logic signed [31:0] s0_val;
    logic signed [31:0] s8_p_reg, s8_sh_reg;

    logic signed [31:0] s_val;
    logic signed [31:0] s9_hv_reg;

    logic signed [31:0] hs_val;
    logic signed [31:0] s10_hv_reg, s10_hh_reg;

    logic signed [31:0] s11_hv_reg, s11_m_reg;

    logic signed [31:0] hc_val, hclamp_val;
    thc_pkg::out_item_t out_reg;

    assign h1_x = {24'b0, cal.h1};
    assign h2_x = {{16{cal.h2[15]}}, cal.h2};
    assign h3_x = {24'b0, cal.h3};
    assign h4_x = {{20{cal.h45[11]}}, cal.h45[11:0]};
    assign h5_x = {{20{cal.h45[23]}}, cal.h45[23:12]};
    assign h6_x = {{24{cal.h6[7]}}, cal.h6};

    assign p_next = $signed({2'b0, s6_h_reg, 14'b0} - {h4_x[11:0], 20'b0} - s6_m5_reg
                            + thc_pkg::HUM_ROUND) >>> 15;
    assign q_val  = s6_q0_reg >>> 10;
    assign r_val  = (s6_r0_reg >>> 11) + thc_pkg::HUM_H3_BIAS;
    assign s0_val = (s7_qr_reg >>> 10) + thc_pkg::HUM_H2_BIAS;
    assign s_val  = (s8_sh_reg + thc_pkg::HUM_GAIN_ROUND) >>> 14;
    assign hs_val = s9_hv_reg >>> 15;
    assign hc_val = s11_hv_reg - (s11_m_reg >>> 4);

    always_comb
    begin
        if (hc_val[31])
            hclamp_val = '0;
        else if (hc_val > thc_pkg::HUM_MAX)
            hclamp_val = thc_pkg::HUM_MAX;
        else
            hclamp_val = hc_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c6_reg     <= '{fine: in_stage.fine, temp: in_stage.temp_centi};
            s6_m5_reg  <= h5_x * in_stage.x;
            s6_q0_reg  <= in_stage.x * h6_x;
            s6_r0_reg  <= in_stage.x * h3_x;
            s6_h_reg   <= in_stage.raw_humidity;

            c7_reg     <= c6_reg;
            s7_p_reg   <= p_next;
            s7_qr_reg  <= q_val * r_val;

            c8_reg     <= c7_reg;
            s8_p_reg   <= s7_p_reg;
            s8_sh_reg  <= s0_val * h2_x;

            c9_reg     <= c8_reg;
            s9_hv_reg  <= s8_p_reg * s_val;

            c10_reg    <= c9_reg;
            s10_hv_reg <= s9_hv_reg;
            s10_hh_reg <= hs_val * hs_val;

            c11_reg    <= c10_reg;
            s11_hv_reg <= s10_hv_reg;
            s11_m_reg  <= (s10_hh_reg >>> 7) * h1_x;

            out_reg.temperature_centi <= c11_reg.temp;
            out_reg.fine_temperature  <= c11_reg.fine;
            out_reg.humidity_q10      <= hclamp_val[28:12];
        end
    end

    assign out_valid = valid_reg[6];
    assign out_data  = out_reg;

endmodule

// ===== design/temp_humidity_compensation_unit.sv =====
`timescale 1ns / 1ps
// Top level of the temperature/humidity compensation block: calibration registers,
// pipeline flow control, and the two datapath pipes. Depends on thc_pkg,
// thc_temp_pipe and thc_hum_pipe.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one raw temperature and humidity pair
//   per item. out channel (out_valid/out_ready/out_data): one compensated result
//   per input item, in order.
//   Config port (cfg_we/cfg_index/cfg_wdata): writes a calibration word;
//   write only while no item is in flight.
// Pipeline: 5 temperature stages, 6 humidity stages and one output register;
//   no stage chains two multipliers.
// Throughput: one item per cycle when not stalled; the whole pipeline advances as one.
// Stall: while out_valid is high and out_ready low, every stage holds and
//   in_ready drops; nothing is lost or repeated. Bubbles travel as cleared
//   valid bits and never block a following item.
// Reset: clears all valid bits and all calibration words to zero.
module temp_humidity_compensation_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  thc_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output thc_pkg::out_item_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [2:0]                           cfg_index,
    input  logic [thc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    thc_pkg::cal_t        cal_reg;
    thc_pkg::temp_stage_t temp_stage;
    logic                 temp_valid;
    logic                 en;

    // Advance the whole pipe unless the output item is waiting on the receiver
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Calibration registers; extra data bits are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                thc_pkg::REG_TEMP_CAL_1:  cal_reg.t1  <= cfg_wdata[15:0];
                thc_pkg::REG_TEMP_CAL_2:  cal_reg.t2  <= cfg_wdata[15:0];
                thc_pkg::REG_TEMP_CAL_3:  cal_reg.t3  <= cfg_wdata[15:0];
                thc_pkg::REG_HUM_CAL_1:   cal_reg.h1  <= cfg_wdata[7:0];
                thc_pkg::REG_HUM_CAL_2:   cal_reg.h2  <= cfg_wdata[15:0];
                thc_pkg::REG_HUM_CAL_3:   cal_reg.h3  <= cfg_wdata[7:0];
                thc_pkg::REG_HUM_CAL_4_5: cal_reg.h45 <= cfg_wdata[23:0];
                thc_pkg::REG_HUM_CAL_6:   cal_reg.h6  <= cfg_wdata[7:0];
                default:                  cal_reg     <= cal_reg;
            endcase
        end
    end

    // Temperature math: fine value, centi-degrees, humidity temperature offset
    thc_temp_pipe u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .cal       (cal_reg),
        .out_valid (temp_valid),
        .out_stage (temp_stage)
    );

    // Humidity math, clamp, and the output register
    thc_hum_pipe u_hum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (temp_valid),
        .in_stage  (temp_stage),
        .cal       (cal_reg),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // The receiver being ready must always open the input side
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while out_ready high");

    // Humidity never leaves the clamp range
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.humidity_q10 <= thc_pkg::HUM_Q10_MAX))
        else $error("humidity out of range");

    // A held output item stays valid and unchanged until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output item changed while stalled");

    // Input blocks only on an output stall
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready) |-> (out_valid && !out_ready))
        else $error("input blocked without an output stall");

endmodule

// ===== tb/sv/temp_humidity_compensation_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for temp_humidity_compensation_unit: random sender and
// receiver idling, calibration sweeps and a scoreboard that predicts every result.
// Depends on thc_pkg and the design files under design/.

// Scoreboard: holds the calibration mirror and the queue of predicted results.
class compensation_scoreboard;
    localparam int MAX_REPORTS = 10;

    thc_pkg::cal_t      cal;
    thc_pkg::out_item_t expected_readings[$];
    int                 errors;

    function new();
        cal    = '0;
        errors = 0;
    endfunction

    // Arithmetic shift right of a 32-bit two's complement word.
    function logic [31:0] asr(logic [31:0] v, int unsigned n);
        return $signed(v) >>> n;
    endfunction

    // Fixed-point compensation; every step wraps at 32 bits.
    function thc_pkg::out_item_t compensate(thc_pkg::in_item_t s);
        logic [31:0] adc_t, adc_h;
        logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [31:0] d, fine, tc, x, p, q, r, g, h, hs, acc;
        thc_pkg::out_item_t o;
        adc_t = 32'(s.raw_temperature);
        adc_h = 32'(s.raw_humidity);
        t1 = 32'(cal.t1);
        t2 = {{16{cal.t2[15]}}, cal.t2};
        t3 = {{16{cal.t3[15]}}, cal.t3};
        h1 = 32'(cal.h1);
        h2 = {{16{cal.h2[15]}}, cal.h2};
        h3 = 32'(cal.h3);
        h4 = {{20{cal.h45[11]}}, cal.h45[11:0]};
        h5 = {{20{cal.h45[23]}}, cal.h45[23:12]};
        h6 = {{24{cal.h6[7]}}, cal.h6};

        acc  = ((adc_t >> 3) - (t1 << 1)) * t2;
        fine = asr(acc, 11);
        d    = (adc_t >> 4) - t1;
        acc  = asr(d * d, 12) * t3;
        fine = fine + asr(acc, 14);
        tc   = asr(fine * 5 + thc_pkg::TEMP_ROUND, 8);

        x = fine - thc_pkg::HUM_T_OFFSET;
        p = asr((adc_h << 14) - (h4 << 20) - h5 * x + thc_pkg::HUM_ROUND, 15);
        q = asr(x * h6, 10);
        r = asr(x * h3, 11) + thc_pkg::HUM_H3_BIAS;
        g = asr(q * r, 10) + thc_pkg::HUM_H2_BIAS;
        g = asr(g * h2 + thc_pkg::HUM_GAIN_ROUND, 14);
        h = p * g;
        hs  = asr(h, 15);
        acc = asr(hs * hs, 7);
        h = h - asr(acc * h1, 4);
        if (h[31])
            h = '0;
        if ($signed(h) > thc_pkg::HUM_MAX)
            h = thc_pkg::HUM_MAX;

        o.temperature_centi = tc[23:0];
        o.fine_temperature  = fine;
        o.humidity_q10      = h[28:12];
        return o;
    endfunction

    function void flag(string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: MISMATCH %s", $time, what);
    endfunction

    function void note_reading(thc_pkg::in_item_t s);
        expected_readings.push_back(compensate(s));
    endfunction

    function void check_result(thc_pkg::out_item_t got);
        thc_pkg::out_item_t want;
        if (expected_readings.size() == 0)
        begin
            flag($sformatf("result with nothing pending: %h", got));
            return;
        end
        want = expected_readings.pop_front();
        if (got.temperature_centi !== want.temperature_centi)
            flag($sformatf("temperature_centi exp %0d got %0d",
                           want.temperature_centi, got.temperature_centi));
        if (got.fine_temperature !== want.fine_temperature)
            flag($sformatf("fine_temperature exp %0d got %0d",
                           want.fine_temperature, got.fine_temperature));
        if (got.humidity_q10 !== want.humidity_q10)
            flag($sformatf("humidity_q10 exp %0d got %0d",
                           want.humidity_q10, got.humidity_q10));
    endfunction
endclass

module temp_humidity_compensation_unit_tb;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 20;      // covers the whole pipeline plus margin
    localparam int HOLD_CYCLES  = 80;      // long receiver hold-off, fills the pipe
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum int {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_COIN} rx_mode_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    thc_pkg::in_item_t              in_data;
    logic                           out_valid;
    logic                           out_ready;
    thc_pkg::out_item_t             out_data;
    logic                           cfg_we;
    logic [2:0]                     cfg_index;
    logic [thc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    compensation_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left  = 0;
    bit random_phase = 1'b0;   // tells the receiver that the long hold-off may start
    bit hold_done    = 1'b0;

    temp_humidity_compensation_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Watch both channels at the rising edge; every handshake is one item.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_reading(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Watchdog: end the run if the traffic never drains.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Receiver: alternate stall patterns of random length. Once random traffic
    // starts, hold off for one long stretch so the pipe fills and in_ready drops.
    initial
    begin : receiver
        rx_mode_t mode;
        int       span;
        out_ready = 1'b0;
        forever
        begin
            if (random_phase && !hold_done)
            begin
                hold_done = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                mode = rx_mode_t'($urandom_range(RX_STEADY, RX_COIN));
                span = $urandom_range(4, 40);
                repeat (span)
                begin
                    @(negedge clk);
                    case (mode)
                        RX_STEADY: out_ready <= 1'b1;
                        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                        default:   out_ready <= 1'(($urandom_range(0, 1)));
                    endcase
                end
            end
        end
    end

    function automatic thc_pkg::in_item_t reading(logic [19:0] raw_t, logic [15:0] raw_h);
        thc_pkg::in_item_t r;
        r.raw_temperature = raw_t;
        r.raw_humidity    = raw_h;
        return r;
    endfunction

    // A quarter of the items span the full field range; the rest sit in the
    // range a real sensor produces, so the humidity math is not always clamped.
    function automatic thc_pkg::in_item_t random_reading();
        if ($urandom_range(0, 3) == 0)
            return reading(20'($urandom_range(0, 20'hFFFFF)), 16'($urandom_range(0, 16'hFFFF)));
        return reading(20'($urandom_range(380000, 640000)), 16'($urandom_range(15000, 50000)));
    endfunction

    // Offer one item and hold it until accepted. Items go out in bursts of
    // random length; between bursts drop valid for a random gap, sometimes none.
    task automatic offer_reading(thc_pkg::in_item_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic finish_offer();
        @(negedge clk);
        in_valid  <= 1'b0;
        burst_left = 0;
    endtask

    task automatic run_random(int count);
        repeat (count) offer_reading(random_reading());
        finish_offer();
    endtask

    // Wait for every predicted result, then let the pipe run empty.
    task automatic settle();
        while (sb.expected_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write per falling edge; mirror the truncation to register width.
    task automatic write_reg(logic [2:0] idx, logic [thc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            thc_pkg::REG_TEMP_CAL_1:  sb.cal.t1  = data[15:0];
            thc_pkg::REG_TEMP_CAL_2:  sb.cal.t2  = data[15:0];
            thc_pkg::REG_TEMP_CAL_3:  sb.cal.t3  = data[15:0];
            thc_pkg::REG_HUM_CAL_1:   sb.cal.h1  = data[7:0];
            thc_pkg::REG_HUM_CAL_2:   sb.cal.h2  = data[15:0];
            thc_pkg::REG_HUM_CAL_3:   sb.cal.h3  = data[7:0];
            thc_pkg::REG_HUM_CAL_4_5: sb.cal.h45 = data[23:0];
            thc_pkg::REG_HUM_CAL_6:   sb.cal.h6  = data[7:0];
            default: ;
        endcase
    endtask

    task automatic program_cal(logic [23:0] t1, logic [23:0] t2, logic [23:0] t3,
                               logic [23:0] h1, logic [23:0] h2, logic [23:0] h3,
                               logic [23:0] h45, logic [23:0] h6);
        write_reg(thc_pkg::REG_TEMP_CAL_1, t1);
        write_reg(thc_pkg::REG_TEMP_CAL_2, t2);
        write_reg(thc_pkg::REG_TEMP_CAL_3, t3);
        write_reg(thc_pkg::REG_HUM_CAL_1, h1);
        write_reg(thc_pkg::REG_HUM_CAL_2, h2);
        write_reg(thc_pkg::REG_HUM_CAL_3, h3);
        write_reg(thc_pkg::REG_HUM_CAL_4_5, h45);
        write_reg(thc_pkg::REG_HUM_CAL_6, h6);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Calibration words scattered around those of a typical part.
    task automatic program_plausible_cal();
        program_cal(24'($urandom_range(26000, 29500)), 24'($urandom_range(25000, 27500)),
                    24'(int'($urandom_range(0, 1500)) - 1000), 24'($urandom_range(0, 255)),
                    24'($urandom_range(300, 420)), 24'($urandom_range(0, 30)),
                    {12'($urandom_range(0, 100)), 12'($urandom_range(250, 400))},
                    24'($urandom_range(0, 60)));
    endtask

    // Full 24-bit words everywhere: the bits above each register are dropped.
    task automatic program_noise_cal();
        program_cal(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                    24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                    24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                    24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
    endtask

    initial
    begin : stimulus
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = thc_pkg::REG_TEMP_CAL_1;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Calibration straight out of reset is all zero; push the raw extremes.
        offer_reading(reading(20'h00000, 16'h0000));
        offer_reading(reading(20'hFFFFF, 16'hFFFF));
        offer_reading(reading(20'hFFFFF, 16'h0000));
        offer_reading(reading(20'h00000, 16'hFFFF));
        finish_offer();
        settle();

        // Typical part: T1 27504, T2 26435, T3 -1000, H1 75, H2 362, H3 0,
        // H4 324, H5 50, H6 30.
        program_cal(24'd27504, 24'd26435, 24'(-1000), 24'd75, 24'd362, 24'd0,
                    {12'd50, 12'd324}, 24'd30);
        offer_reading(reading(20'h00000, 16'h0000));
        offer_reading(reading(20'hFFFFF, 16'hFFFF));
        offer_reading(reading(20'hFFFFF, 16'h0000));
        offer_reading(reading(20'h00000, 16'hFFFF));
        offer_reading(reading(20'hAAAAA, 16'h5555));
        offer_reading(reading(20'h55555, 16'hAAAA));
        offer_reading(reading(20'd519888, 16'd30000));   // about 25 degrees, mid humidity
        offer_reading(reading(20'd519888, 16'd0));       // humidity clamps at zero
        offer_reading(reading(20'd519888, 16'd65535));   // humidity clamps at full scale
        offer_reading(reading(20'd415148, 16'd40000));
        offer_reading(reading(20'd600000, 16'd20000));
        offer_reading(reading(20'd440064, 16'd32768));   // raw/16 equals T1: no square term
        offer_reading(reading(20'd1, 16'd1));
        offer_reading(reading(20'd80000, 16'd60000));
        finish_offer();
        settle();

        // Random traffic on the typical part; the long hold-off happens here.
        random_phase = 1'b1;
        run_random(150);
        settle();

        repeat (3)
        begin
            program_plausible_cal();
            run_random(80);
            settle();
        end

        // All ones: every register at its top code, signed words at -1.
        program_cal(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        run_random(60);
        settle();

        // Most negative signed words, unsigned words at zero.
        program_cal(24'h000000, 24'h008000, 24'h008000, 24'h000000,
                    24'h008000, 24'h000000, 24'h800800, 24'h000080);
        run_random(60);
        settle();

        // Most positive signed words, unsigned words at their top.
        program_cal(24'h00FFFF, 24'h007FFF, 24'h007FFF, 24'h0000FF,
                    24'h007FFF, 24'h0000FF, 24'h7FF7FF, 24'h00007F);
        run_random(60);
        settle();

        repeat (2)
        begin
            program_noise_cal();
            run_random(60);
            settle();
        end

        // Anything still queued never came out.
        if (sb.errors == 0 && sb.expected_readings.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
